/* src/assert_macros.svh */
// Assertion macros for the RTL modules; the top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dhp_pkg.sv */
// Shared types, constants and tables of the DLC history prefetch predictor.
package dhp_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int DLC_W      = 4;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_BINS   = 16;

    localparam logic [DLC_W-1:0]      TOP_FD      = 4'd15;
    localparam logic [DLC_W-1:0]      TOP_CLASSIC = 4'd8;
    localparam logic [DLC_W-1:0]      DLC_EMPTY   = 4'd8;
    localparam logic [LEN_W-1:0]      CAP_FD      = 7'd64;
    localparam logic [LEN_W-1:0]      CAP_CLASSIC = 7'd8;
    localparam logic [CFG_DATA_W-1:0] OVR_RESET   = 8'd8;

    // DLC to payload byte count
    localparam logic [LEN_W-1:0] DLC_TO_LEN [NUM_BINS] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
        7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FD_MODE   = 2'd0,
        REG_OVR_EN    = 2'd1,
        REG_OVR_BYTES = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_INC,
        HOP_DEC,
        HOP_CMP
    } hist_op_t;

    typedef struct packed {
        hist_op_t         op;
        logic [DLC_W-1:0] bin;
        logic             restart;
    } hist_ctl_t;

endpackage

/* src/dhp_if.sv */
// Request channel interfaces for frame DLCs and predictions.
interface dhp_in_if;
    import dhp_pkg::*;
    logic             valid;
    logic             ready;
    logic [DLC_W-1:0] frame_dlc;

    modport source (output valid, output frame_dlc, input ready);
    modport sink   (input valid, input frame_dlc, output ready);
endinterface

interface dhp_out_if;
    import dhp_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] predicted_len;
    logic [DLC_W-1:0] predicted_dlc;

    modport source (output valid, output predicted_len, output predicted_dlc, input ready);
    modport sink   (input valid, input predicted_len, input predicted_dlc, output ready);
endinterface

/* src/dhp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dhp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* src/dhp_hist.sv */
// Histogram bins with one shared add/subtract and compare unit.
module dhp_hist
    import dhp_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_DEPTH,
    parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hist_ctl_t        ctl,
    output logic [DLC_W-1:0] best_dlc
);

    logic [CNT_W-1:0] bins_reg [NUM_BINS];
    logic [CNT_W-1:0] best_cnt_reg;
    logic [DLC_W-1:0] best_dlc_reg;

    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] sum;
    logic             greater;

    // one operand per cycle: the addressed bin
    always_comb
    begin
        cur     = bins_reg[ctl.bin];
        sum     = (ctl.op == HOP_INC) ? cur + CNT_W'(1) : cur - CNT_W'(1);
        greater = cur > best_cnt_reg;
    end

    // ring starts all zero, so every entry counts in bin 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bins_reg[i] <= (i == 0) ? CNT_W'(HISTORY_DEPTH) : '0;
            end
            best_cnt_reg <= '0;
            best_dlc_reg <= DLC_EMPTY;
        end
        else
        begin
            case (ctl.op) inside
                HOP_INC, HOP_DEC:
                begin
                    bins_reg[ctl.bin] <= sum;
                end
                HOP_CMP:
                begin
                    // strict compare, walked downwards: highest code wins a tie
                    if (greater)
                    begin
                        best_cnt_reg <= cur;
                        best_dlc_reg <= ctl.bin;
                    end
                end
                default:
                begin
                end
            endcase
            if (ctl.restart)
            begin
                best_cnt_reg <= '0;
                best_dlc_reg <= DLC_EMPTY;
            end
        end
    end

    assign best_dlc = best_dlc_reg;

endmodule

/* src/dlc_history_prefetch_predictor_top.sv */
// Top level of the DLC history prefetch predictor: sequencer, config and output register.
// A request steps through ST_DEC, ST_INC, a bin walk in ST_SEARCH down from the top code
// (15 in FD mode, 8 in classic) to 0, and ST_DONE, which loads the output register once it
// is free. Requests are accepted only in ST_IDLE, after the last one has left ST_DONE;
// a finished result waits in the output register while the next request is accepted.
// Reset (rst_n, async, active low): ring reads as all zero, write slot 0, fd_mode 0,
// override off, override bytes 8. No clearing pass is needed.
`include "assert_macros.svh"

module dlc_history_prefetch_predictor_top
    import dhp_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dhp_in_if.sink                in_ch,
    dhp_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_INC,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [PTR_W-1:0]     pos_reg;
    logic                 wrapped_reg;
    logic [DLC_W-1:0]     dlc_reg;
    logic [DLC_W-1:0]     idx_reg;

    logic                 fd_mode_reg;
    logic                 ovr_en_reg;
    logic [CFG_DATA_W-1:0] ovr_bytes_reg;

    logic                 out_valid_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [DLC_W-1:0]     out_dlc_reg;

    logic                 accept;
    logic                 out_free;
    logic [DLC_W-1:0]     ram_rdata;
    logic [DLC_W-1:0]     old_dlc;
    logic [DLC_W-1:0]     best_dlc;
    logic [DLC_W-1:0]     top_dlc;
    logic [LEN_W-1:0]     cap;
    logic [LEN_W-1:0]     len_next;
    logic [DLC_W-1:0]     dlc_next;
    hist_ctl_t            hist_ctl;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Slots ahead of the write pointer are unwritten until the first lap ends;
    // they hold the reset value zero.
    assign old_dlc = wrapped_reg ? ram_rdata : '0;

    assign top_dlc = fd_mode_reg ? TOP_FD : TOP_CLASSIC;
    assign cap     = fd_mode_reg ? CAP_FD : CAP_CLASSIC;

    // final answer: override clamp, or table lookup of the winning code
    always_comb
    begin
        if (ovr_en_reg)
        begin
            len_next = (ovr_bytes_reg < {1'b0, cap}) ? ovr_bytes_reg[LEN_W-1:0] : cap;
            dlc_next = DLC_EMPTY;
        end
        else
        begin
            len_next = DLC_TO_LEN[best_dlc];
            dlc_next = best_dlc;
        end
    end

    // histogram control: drop the evicted code, add the new one, then walk bins down
    always_comb
    begin
        hist_ctl.op      = HOP_NONE;
        hist_ctl.bin     = idx_reg;
        hist_ctl.restart = 1'b0;
        unique case (state_reg)
            ST_DEC:
            begin
                hist_ctl.op  = HOP_DEC;
                hist_ctl.bin = old_dlc;
            end
            ST_INC:
            begin
                hist_ctl.op      = HOP_INC;
                hist_ctl.bin     = dlc_reg;
                hist_ctl.restart = 1'b1;
            end
            ST_SEARCH:
            begin
                hist_ctl.op  = HOP_CMP;
                hist_ctl.bin = idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    dhp_ram #(
        .WIDTH (DLC_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_DEC),
        .waddr (pos_reg),
        .wdata (dlc_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    dhp_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hist_ctl),
        .best_dlc (best_dlc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            dlc_reg       <= '0;
            idx_reg       <= '0;
            fd_mode_reg   <= 1'b0;
            ovr_en_reg    <= 1'b0;
            ovr_bytes_reg <= OVR_RESET;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_dlc_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FD_MODE:   fd_mode_reg   <= cfg_wdata[0];
                    REG_OVR_EN:    ovr_en_reg    <= cfg_wdata[0];
                    REG_OVR_BYTES: ovr_bytes_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end

            // in ST_DONE a taken result is replaced below instead
            if (out_valid_reg && out_ch.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        dlc_reg   <= in_ch.frame_dlc;
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC:
                begin
                    // ring write happens this cycle; advance the slot
                    if (pos_reg == PTR_W'(HISTORY_DEPTH - 1))
                    begin
                        pos_reg     <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PTR_W'(1);
                    end
                    state_reg <= ST_INC;
                end
                ST_INC:
                begin
                    idx_reg   <= top_dlc;
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH:
                begin
                    if (idx_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - DLC_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_len_reg   <= len_next;
                        out_dlc_reg   <= dlc_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.predicted_len = out_len_reg;
    assign out_ch.predicted_dlc = out_dlc_reg;

    `ASSERT_NEXT(a_accept_starts_update, accept, state_reg == ST_DEC, "request did not start update")
    `ASSERT_IMPLIES(a_len_capped, out_ch.valid, out_ch.predicted_len <= CAP_FD, "length above 64")
    `ASSERT_IMPLIES(a_override_dlc, out_ch.valid && ovr_en_reg, out_ch.predicted_dlc == DLC_EMPTY, "override code not 8")
    `ASSERT_IMPLIES(a_classic_range, out_ch.valid && !fd_mode_reg, out_ch.predicted_dlc <= TOP_CLASSIC, "classic code above 8")

endmodule
